FILE: design/smx_pkg.sv
// Shared types and constants for the segmented softmax block.
package smx_pkg;

  localparam int DataW = 16;
  localparam int SumW  = 23;
  localparam int ResW  = 18;
  localparam int ColW  = 7;

  // configuration register indexes
  localparam logic REG_LOG_MODE = 1'b0;
  localparam logic REG_COLUMNS  = 1'b1;

  // exp(-2^(k-10)) in Q24, one factor per bit of the distance to the max
  localparam logic [23:0] EXP_F [0:13] = '{
    24'd16760840, 24'd16744480, 24'd16711808, 24'd16646655, 24'd16517109,
    24'd16261035, 24'd15760736, 24'd14805841, 24'd13066109, 24'd10175896,
    24'd6171993,  24'd2270549,  24'd307285,   24'd5628
  };

  typedef struct packed {
    logic load_rd;
    logic load_wr;
    logic pass_init;
    logic rd;
    logic exp_go;
    logic sum_wr;
    logic ln_go;
    logic div_go;
    logic set_res;
    logic emit;
    logic advance;
    logic clear;
  } cmd_t;

  typedef struct packed {
    logic seg_end;
    logic last_elem;
    logic log_mode;
    logic sum_zero;
    logic exp_done;
    logic ln_done;
    logic div_done;
  } sts_t;

endpackage

FILE: design/smx_ctrl.sv
// Controller state machine: load, exp-and-sum pass, normalize-and-emit pass.
module smx_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  smx_pkg::sts_t    sts,
  output smx_pkg::cmd_t    cmd
);

  localparam logic [3:0] ST_IDLE     = 4'd0;
  localparam logic [3:0] ST_LOAD     = 4'd1;
  localparam logic [3:0] ST_P1_RD    = 4'd2;
  localparam logic [3:0] ST_P1_EXP   = 4'd3;
  localparam logic [3:0] ST_P1_WAIT  = 4'd4;
  localparam logic [3:0] ST_P1_WR    = 4'd5;
  localparam logic [3:0] ST_P2_RD    = 4'd6;
  localparam logic [3:0] ST_P2_GO    = 4'd7;
  localparam logic [3:0] ST_P2_WAIT  = 4'd8;
  localparam logic [3:0] ST_P2_DWAIT = 4'd9;
  localparam logic [3:0] ST_P2_OUT   = 4'd10;

  logic [3:0] state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != ST_IDLE);

  always_comb begin
    state_next = state;
    cmd = '0;
    case (state)
      ST_IDLE: begin
        if (start) begin
          cmd.load_rd = 1'b1;
          state_next = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_wr = 1'b1;
        if (sts.seg_end) begin
          cmd.pass_init = 1'b1;
          state_next = ST_P1_RD;
        end else begin
          state_next = ST_IDLE;
        end
      end
      ST_P1_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_P1_EXP;
      end
      ST_P1_EXP: begin
        cmd.exp_go = 1'b1;
        state_next = ST_P1_WAIT;
      end
      ST_P1_WAIT: begin
        if (sts.exp_done) state_next = ST_P1_WR;
      end
      ST_P1_WR: begin
        cmd.sum_wr = 1'b1;
        if (sts.last_elem) begin
          cmd.pass_init = 1'b1;
          state_next = ST_P2_RD;
        end else begin
          cmd.advance = 1'b1;
          state_next = ST_P1_RD;
        end
      end
      ST_P2_RD: begin
        cmd.rd = 1'b1;
        state_next = ST_P2_GO;
      end
      ST_P2_GO: begin
        if (sts.log_mode) cmd.ln_go = 1'b1;
        else cmd.exp_go = 1'b1;
        state_next = ST_P2_WAIT;
      end
      ST_P2_WAIT: begin
        if (sts.log_mode && sts.ln_done) begin
          cmd.set_res = 1'b1;
          state_next = ST_P2_OUT;
        end else if (!sts.log_mode && sts.exp_done) begin
          if (sts.sum_zero) begin
            cmd.set_res = 1'b1;
            state_next = ST_P2_OUT;
          end else begin
            cmd.div_go = 1'b1;
            state_next = ST_P2_DWAIT;
          end
        end
      end
      ST_P2_DWAIT: begin
        if (sts.div_done) begin
          cmd.set_res = 1'b1;
          state_next = ST_P2_OUT;
        end
      end
      ST_P2_OUT: begin
        cmd.emit = 1'b1;
        if (sts.last_elem) begin
          cmd.clear = 1'b1;
          state_next = ST_IDLE;
        end else begin
          cmd.advance = 1'b1;
          state_next = ST_P2_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: design/smx_dp.sv
// Datapath: buffers, column max/sum stores, iterative exp, ln and divide units.
module smx_dp #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic                        clk,
  input  logic                        rst,
  input  smx_pkg::cmd_t               cmd,
  output smx_pkg::sts_t               sts,
  input  logic                        wr_en,
  input  logic                        wr_index,
  input  logic [smx_pkg::ColW-1:0]    wr_data,
  input  logic signed [smx_pkg::DataW-1:0] sample,
  input  logic                        segment_end,
  output logic                        result_valid,
  output logic signed [smx_pkg::ResW-1:0] result_value,
  output logic                        last,
  output logic                        overflowed
);

  localparam int AW = $clog2(MAX_ELEMENTS);
  localparam int CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [smx_pkg::ColW-1:0] MaxCols = smx_pkg::ColW'(MAX_COLUMNS);

  localparam logic [1:0] L_IDLE = 2'd0;
  localparam logic [1:0] L_NORM = 2'd1;
  localparam logic [1:0] L_SQ   = 2'd2;
  localparam logic [1:0] L_MUL  = 2'd3;

  // configuration
  logic                      log_mode;
  logic [smx_pkg::ColW-1:0]  columns;
  logic [CW:0]               eff_cols;

  always_ff @(posedge clk) begin
    if (rst) begin
      log_mode <= 1'b0;
      columns  <= smx_pkg::ColW'(1);
    end else if (wr_en) begin
      case (wr_index)
        smx_pkg::REG_LOG_MODE: log_mode <= wr_data[0];
        smx_pkg::REG_COLUMNS:  columns  <= wr_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (columns == '0) eff_cols = (CW+1)'(1);
    else if (columns > MaxCols) eff_cols = (CW+1)'(MAX_COLUMNS);
    else eff_cols = columns[CW:0];
  end

  // stores
  logic signed [smx_pkg::DataW-1:0] buf_mem  [MAX_ELEMENTS];
  logic signed [smx_pkg::DataW-1:0] cmax_mem [MAX_COLUMNS];
  logic [smx_pkg::SumW-1:0]         csum_mem [MAX_COLUMNS];
  logic [MAX_COLUMNS-1:0]           cmax_vld, csum_vld;

  logic signed [smx_pkg::DataW-1:0] buf_q, cmax_q, x_in;
  logic [smx_pkg::SumW-1:0]         csum_q;
  logic                             cmax_v, csum_v, end_in;

  logic [CW-1:0]  col_idx, ld_col, ld_col_c, pc, rd_addr;
  logic [AW-1:0]  pj;
  logic [AW:0]    count;
  logic           ovf;

  logic signed [smx_pkg::DataW-1:0] mx;
  logic [smx_pkg::SumW-1:0]         sum_cur;
  logic [16:0]                      e_val;

  assign ld_col_c = ({1'b0, col_idx} >= eff_cols) ? '0 : col_idx;
  assign rd_addr  = cmd.load_rd ? ld_col_c : pc;
  assign mx       = cmax_v ? cmax_q : {1'b1, {(smx_pkg::DataW-1){1'b0}}};
  assign sum_cur  = csum_v ? csum_q : '0;

  always_ff @(posedge clk) begin
    if (cmd.load_rd) begin
      x_in   <= sample;
      end_in <= segment_end;
      ld_col <= ld_col_c;
    end
    if (cmd.load_rd || cmd.rd) begin
      cmax_q <= cmax_mem[rd_addr];
      cmax_v <= cmax_vld[rd_addr];
    end
    if (cmd.rd) begin
      buf_q  <= buf_mem[pj];
      csum_q <= csum_mem[pc];
      csum_v <= csum_vld[pc];
    end
    if (cmd.load_wr && count < (AW+1)'(MAX_ELEMENTS)) begin
      buf_mem[count[AW-1:0]] <= x_in;
      if (x_in > mx) cmax_mem[ld_col] <= x_in;
    end
    if (cmd.sum_wr) begin
      csum_mem[pc] <= sum_cur + smx_pkg::SumW'(e_val);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      col_idx  <= '0;
      ovf      <= 1'b0;
      cmax_vld <= '0;
      csum_vld <= '0;
      pj       <= '0;
      pc       <= '0;
    end else begin
      if (cmd.load_wr) begin
        if (count < (AW+1)'(MAX_ELEMENTS)) begin
          count <= count + (AW+1)'(1);
          if (x_in > mx) cmax_vld[ld_col] <= 1'b1;
        end else begin
          ovf <= 1'b1;
        end
        col_idx <= (({1'b0, ld_col} + (CW+1)'(1)) >= eff_cols) ? '0 : ld_col + CW'(1);
      end
      if (cmd.sum_wr) csum_vld[pc] <= 1'b1;
      if (cmd.pass_init) begin
        pj <= '0;
        pc <= '0;
      end else if (cmd.advance) begin
        pj <= pj + AW'(1);
        pc <= (({1'b0, pc} + (CW+1)'(1)) >= eff_cols) ? '0 : pc + CW'(1);
      end
      if (cmd.clear) begin
        count    <= '0;
        col_idx  <= '0;
        ovf      <= 1'b0;
        cmax_vld <= '0;
        csum_vld <= '0;
      end
    end
  end

  // exp unit: one factor per cycle over the 14 distance bits
  logic        e_run, e_fin;
  logic [3:0]  e_k;
  logic [24:0] e_acc;
  logic [13:0] e_y;
  logic [16:0] e_d;
  logic [48:0] e_prod;

  assign e_d    = 17'($signed({mx[15], mx}) - $signed({buf_q[15], buf_q}));
  assign e_prod = 49'(e_acc) * 49'(smx_pkg::EXP_F[e_k]) + 49'(24'h800000);
  assign e_val  = 17'((26'(e_acc) + 26'd128) >> 8);

  always_ff @(posedge clk) begin
    if (cmd.exp_go) begin
      e_y   <= e_d[16] ? '0 : e_d[13:0];
      e_acc <= (!e_d[16] && e_d[15:0] >= 16'd12288) ? '0 : 25'(1) << 24;
      e_k   <= '0;
    end else if (e_run) begin
      if (e_y[e_k]) e_acc <= e_prod[48:24];
      e_k <= e_k + 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      e_run <= 1'b0;
      e_fin <= 1'b0;
    end else begin
      e_fin <= e_run && (e_k == 4'd13);
      if (cmd.exp_go) e_run <= 1'b1;
      else if (e_k == 4'd13) e_run <= 1'b0;
    end
  end

  // ln unit: normalize, 16 squaring rounds, then scale by ln 2
  logic [1:0]          l_st;
  logic [31:0]         l_m;
  logic [4:0]          l_n;
  logic [3:0]          l_i;
  logic [15:0]         l_frac;
  logic signed [38:0]  l_p;
  logic                l_done;
  logic [63:0]         l_sq;
  logic signed [21:0]  l_lg;
  logic signed [38:0]  l_rnd;
  logic signed [16:0]  ln_val;

  assign l_sq   = 64'(l_m) * 64'(l_m);
  assign l_lg   = {6'($signed({1'b0, l_n}) - 6'sd16), l_frac};
  assign l_rnd  = l_p + 39'sd2097152;
  assign ln_val = l_rnd[38:22];

  always_ff @(posedge clk) begin
    if (rst) begin
      l_st   <= L_IDLE;
      l_done <= 1'b0;
    end else begin
      l_done <= 1'b0;
      case (l_st)
        L_IDLE: if (cmd.ln_go) l_st <= L_NORM;
        L_NORM: if (l_m[22]) l_st <= L_SQ;
        L_SQ:   if (l_i == 4'd15) l_st <= L_MUL;
        L_MUL: begin
          l_st   <= L_IDLE;
          l_done <= 1'b1;
        end
        default: l_st <= L_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    case (l_st)
      L_IDLE: begin
        if (cmd.ln_go) begin
          l_m <= {9'b0, (sum_cur == '0) ? smx_pkg::SumW'(1) : sum_cur};
          l_n <= 5'd22;
        end
      end
      L_NORM: begin
        if (l_m[22]) begin
          l_m    <= l_m << 8;
          l_i    <= '0;
          l_frac <= '0;
        end else begin
          l_m <= l_m << 1;
          l_n <= l_n - 5'd1;
        end
      end
      L_SQ: begin
        if (l_sq[61]) begin
          l_m    <= {1'b0, l_sq[61:31]};
          l_frac <= {l_frac[14:0], 1'b1};
        end else begin
          l_m    <= l_sq[61:30];
          l_frac <= {l_frac[14:0], 1'b0};
        end
        l_i <= l_i + 4'd1;
      end
      L_MUL: begin
        l_p <= 39'(l_lg) * 39'sd45426;
      end
      default: ;
    endcase
  end

  // restoring divider, one quotient bit per cycle
  logic        d_run, d_done;
  logic [5:0]  d_i;
  logic [23:0] d_rem, d_r2;
  logic [32:0] d_num, d_q;
  logic        d_bit;

  assign d_r2  = {d_rem[22:0], d_num[32]};
  assign d_bit = (d_r2 >= {1'b0, sum_cur});

  always_ff @(posedge clk) begin
    if (cmd.div_go) begin
      d_num <= {e_val, 16'b0} + 33'(sum_cur >> 1);
      d_rem <= '0;
      d_q   <= '0;
      d_i   <= '0;
    end else if (d_run) begin
      d_rem <= d_bit ? d_r2 - {1'b0, sum_cur} : d_r2;
      d_q   <= {d_q[31:0], d_bit};
      d_num <= d_num << 1;
      d_i   <= d_i + 6'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      d_run  <= 1'b0;
      d_done <= 1'b0;
    end else begin
      d_done <= d_run && (d_i == 6'd32);
      if (cmd.div_go) d_run <= 1'b1;
      else if (d_i == 6'd32) d_run <= 1'b0;
    end
  end

  // result formatting
  logic signed [19:0]          lv;
  logic signed [smx_pkg::ResW-1:0] lv_sat, res_value;
  logic [smx_pkg::ResW-1:0]    pv;

  assign lv = 20'(buf_q) - 20'(mx) - 20'(ln_val);

  always_comb begin
    if (lv > 20'sd131071) lv_sat = 18'sd131071;
    else if (lv < -20'sd131072) lv_sat = -18'sd131072;
    else lv_sat = lv[17:0];
    pv = (d_q > 33'd131071) ? 18'd131071 : d_q[17:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.set_res) begin
      if (log_mode) res_value <= lv_sat;
      else if (sum_cur == '0) res_value <= '0;
      else res_value <= $signed(pv);
    end
    if (cmd.emit) begin
      result_value <= res_value;
      last         <= sts.last_elem;
      overflowed   <= ovf;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) result_valid <= 1'b0;
    else result_valid <= cmd.emit;
  end

  always_comb begin
    sts.seg_end   = end_in;
    sts.last_elem = (({1'b0, pj} + (AW+1)'(1)) == count);
    sts.log_mode  = log_mode;
    sts.sum_zero  = (sum_cur == '0);
    sts.exp_done  = e_fin;
    sts.ln_done   = l_done;
    sts.div_done  = d_done;
  end

endmodule

FILE: design/segmented_softmax.sv
// Top level of the segmented softmax block: controller plus datapath.
// Usage: drive sample and segment_end with start high while busy is low; the
// item is taken at that edge. Elements of a segment come in row-major order;
// segment_end marks the last one. Each element is loaded by a read and then
// an update of its column max, after which start may come again. On the
// closing item the block stays busy through two passes over the buffer: exp
// and column sum, paced by the 14-step exp unit, then normalize and emit,
// paced for probabilities by the exp unit and the 33-step divider (which is
// skipped where the column sum is zero) and for log-softmax by the normalize
// and 16 squaring rounds of the ln unit. Each result shows on result_value,
// last and overflowed for one cycle with result_valid high; the receiver
// cannot stall, so results leave at the pace they are made. Configuration
// (wr_en, wr_index, wr_data) is to be written by the user while busy is low;
// the block itself does not enforce it. Index 0 selects log mode, index 1
// the column count. Synchronous reset clears the segment state and sets
// probability mode with one column.
module segmented_softmax #(
  parameter int MAX_ELEMENTS = 64,
  parameter int MAX_COLUMNS  = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  output logic                             busy,
  input  logic signed [smx_pkg::DataW-1:0] sample,
  input  logic                             segment_end,
  input  logic                             wr_en,
  input  logic                             wr_index,
  input  logic [smx_pkg::ColW-1:0]         wr_data,
  output logic                             result_valid,
  output logic signed [smx_pkg::ResW-1:0]  result_value,
  output logic                             last,
  output logic                             overflowed
);

  smx_pkg::cmd_t cmd;
  smx_pkg::sts_t sts;

  smx_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .sts   (sts),
    .cmd   (cmd)
  );

  smx_dp #(
    .MAX_ELEMENTS (MAX_ELEMENTS),
    .MAX_COLUMNS  (MAX_COLUMNS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .sts          (sts),
    .wr_en        (wr_en),
    .wr_index     (wr_index),
    .wr_data      (wr_data),
    .sample       (sample),
    .segment_end  (segment_end),
    .result_valid (result_valid),
    .result_value (result_value),
    .last         (last),
    .overflowed   (overflowed)
  );

endmodule
